FILE: hdl/greedy_text_line_wrap_unit_assert.svh
// assertion macros for the line wrap unit
`ifndef GREEDY_TEXT_LINE_WRAP_UNIT_ASSERT_SVH
`define GREEDY_TEXT_LINE_WRAP_UNIT_ASSERT_SVH

// property holds in the same cycle
`define GTLW_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("gtlw check failed");

// property holds in the following cycle
`define GTLW_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("gtlw check failed");

`endif

FILE: hdl/gtlw_pkg.sv
package gtlw_pkg;

    localparam int MAX_CHARS = 256;
    localparam int MAX_LINES = 16;

    localparam int ADDR_W = $clog2(MAX_CHARS);
    localparam int LEN_W  = ADDR_W + 1;
    localparam int LINE_W = (MAX_LINES > 1) ? $clog2(MAX_LINES) : 1;
    localparam int LS_W   = 9;
    localparam int CUT_W  = ((LEN_W > LS_W) ? LEN_W : LS_W) + 1;
    localparam int IDX_W  = 1;

    localparam logic [7:0]      SPACE_CHAR      = 8'h20;
    localparam logic [LS_W-1:0] LINE_SIZE_RESET = LS_W'(80);
    localparam logic            SKIP_RESET      = 1'b1;

    localparam logic [IDX_W-1:0] CFG_LINE_SIZE   = IDX_W'(0);
    localparam logic [IDX_W-1:0] CFG_SKIP_SPACES = IDX_W'(1);

    typedef enum logic [5:0] {
        ST_IDLE     = 6'b000001,
        ST_TRIM_RD  = 6'b000010,
        ST_TRIM_CHK = 6'b000100,
        ST_LINE     = 6'b001000,
        ST_SCAN_RD  = 6'b010000,
        ST_SCAN_CHK = 6'b100000
    } t_state;

endpackage

FILE: hdl/greedy_text_line_wrap_unit.sv
// channel   | direction | transfer when              | ports
// ----------+-----------+----------------------------+----------------------------------
// text in   | in        | i_start & !o_busy          | i_text_byte i_has_byte i_end_of_text
// line out  | out       | o_strobe (one cycle)       | o_line_begin o_line_end
//           |           |                            | o_line_number o_last_line
// config    | in        | i_cfg_valid & o_cfg_ready  | i_cfg_index i_cfg_data
//
// a byte without end of text leaves busy low
// the wrap pass uses the single read port of the text store: a read state and a
// check state per leading space skipped, the line state per line decision, and a
// read state and a check state per byte scanned back from the cut; with skipping
// off a line is decided in the line state alone
// synchronous active-low reset empties the text and restores line size 80, skipping on
// no clearing pass; the receiver cannot stall, each line is strobed for one cycle
`include "greedy_text_line_wrap_unit_assert.svh"

module greedy_text_line_wrap_unit (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    output logic                          o_busy,
    input  logic [7:0]                    i_text_byte,
    input  logic                          i_has_byte,
    input  logic                          i_end_of_text,
    output logic                          o_strobe,
    output logic [gtlw_pkg::LEN_W-1:0]    o_line_begin,
    output logic [gtlw_pkg::LEN_W-1:0]    o_line_end,
    output logic [gtlw_pkg::LINE_W-1:0]   o_line_number,
    output logic                          o_last_line,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [gtlw_pkg::IDX_W-1:0]    i_cfg_index,
    input  logic [gtlw_pkg::LS_W-1:0]     i_cfg_data
);

    gtlw_pkg::t_state r_state, n_state;

    logic [gtlw_pkg::LEN_W-1:0]  r_len, n_len;
    logic                        r_ended, n_ended;
    logic [gtlw_pkg::LS_W-1:0]   r_line_size;
    logic                        r_skip;
    logic [gtlw_pkg::LEN_W-1:0]  r_a, n_a;
    logic [gtlw_pkg::LEN_W-1:0]  r_p, n_p;
    logic [gtlw_pkg::LINE_W-1:0] r_k, n_k;
    logic                        r_first, n_first;
    logic                        r_mode_sp, n_mode_sp;
    logic                        r_strobe, n_strobe;
    logic [gtlw_pkg::LEN_W-1:0]  r_begin, n_begin;
    logic [gtlw_pkg::LEN_W-1:0]  r_end, n_end;
    logic [gtlw_pkg::LINE_W-1:0] r_num, n_num;
    logic                        r_last, n_last;

    logic [7:0] r_text_store [gtlw_pkg::MAX_CHARS];
    logic [7:0] r_rdata;

    logic                         w_accept;
    logic                         w_load;
    logic [gtlw_pkg::LS_W-1:0]    w_ls;
    logic [gtlw_pkg::CUT_W-1:0]   w_cut;
    logic                         w_cut_done;
    logic                         w_is_sp;
    logic                         w_k_last;
    logic                         w_mode;
    logic                         w_found;
    logic [gtlw_pkg::LEN_W-1:0]   w_line_end;
    logic                         w_finish;
    logic [gtlw_pkg::ADDR_W-1:0]  w_rd_addr;

    assign w_accept   = i_start && (r_state == gtlw_pkg::ST_IDLE);
    assign w_load     = w_accept && i_has_byte && !r_ended && (i_text_byte != 8'd0)
                        && (r_len < gtlw_pkg::LEN_W'(gtlw_pkg::MAX_CHARS));
    assign w_ls       = (r_line_size == '0) ? gtlw_pkg::LS_W'(1) : r_line_size;
    assign w_cut      = gtlw_pkg::CUT_W'(r_a) + gtlw_pkg::CUT_W'(w_ls);
    assign w_cut_done = w_cut >= gtlw_pkg::CUT_W'(r_len);
    assign w_is_sp    = r_rdata == gtlw_pkg::SPACE_CHAR;
    assign w_k_last   = r_k == gtlw_pkg::LINE_W'(gtlw_pkg::MAX_LINES - 1);
    assign w_mode     = r_first ? w_is_sp : r_mode_sp;
    assign w_rd_addr  = (r_state == gtlw_pkg::ST_TRIM_RD) ? r_a[gtlw_pkg::ADDR_W-1:0]
                                                          : r_p[gtlw_pkg::ADDR_W-1:0];

    // where a backward scan ends the line
    always_comb begin
        w_found    = 1'b0;
        w_line_end = gtlw_pkg::LEN_W'(w_cut);
        if (r_state == gtlw_pkg::ST_SCAN_CHK) begin
            if (w_mode) begin
                if (!w_is_sp) begin
                    w_found    = 1'b1;
                    w_line_end = r_p + gtlw_pkg::LEN_W'(1);
                end else if (r_p == r_a) begin
                    w_found = 1'b1;
                end
            end else begin
                if (w_is_sp) begin
                    w_found = 1'b1;
                    if (r_p > r_a) begin
                        w_line_end = r_p;
                    end
                end else if (r_p == r_a) begin
                    w_found = 1'b1;
                end
            end
        end
    end

    always_comb begin
        n_state   = r_state;
        n_len     = r_len;
        n_ended   = r_ended;
        n_a       = r_a;
        n_p       = r_p;
        n_k       = r_k;
        n_first   = r_first;
        n_mode_sp = r_mode_sp;
        n_strobe  = 1'b0;
        n_begin   = r_begin;
        n_end     = r_end;
        n_num     = r_num;
        n_last    = r_last;
        w_finish  = 1'b0;

        case (r_state)
            gtlw_pkg::ST_IDLE: begin
                if (w_accept) begin
                    if (i_has_byte && !r_ended && (i_text_byte == 8'd0)) begin
                        n_ended = 1'b1;
                    end
                    if (w_load) begin
                        n_len = r_len + gtlw_pkg::LEN_W'(1);
                    end
                    if (i_end_of_text) begin
                        n_a     = '0;
                        n_k     = '0;
                        n_state = r_skip ? gtlw_pkg::ST_TRIM_RD : gtlw_pkg::ST_LINE;
                    end
                end
            end
            gtlw_pkg::ST_TRIM_RD: begin
                n_state = (r_a >= r_len) ? gtlw_pkg::ST_LINE : gtlw_pkg::ST_TRIM_CHK;
            end
            gtlw_pkg::ST_TRIM_CHK: begin
                if (w_is_sp) begin
                    n_a     = r_a + gtlw_pkg::LEN_W'(1);
                    n_state = gtlw_pkg::ST_TRIM_RD;
                end else begin
                    n_state = gtlw_pkg::ST_LINE;
                end
            end
            gtlw_pkg::ST_LINE: begin
                if (w_cut_done) begin
                    // rest of the text fits on this line
                    n_strobe = 1'b1;
                    n_begin  = r_a;
                    n_end    = r_len;
                    n_num    = r_k;
                    n_last   = 1'b1;
                    n_len    = '0;
                    n_ended  = 1'b0;
                    n_state  = gtlw_pkg::ST_IDLE;
                end else if (!r_skip) begin
                    w_finish = 1'b1;
                end else begin
                    n_p     = gtlw_pkg::LEN_W'(w_cut);
                    n_first = 1'b1;
                    n_state = gtlw_pkg::ST_SCAN_RD;
                end
            end
            gtlw_pkg::ST_SCAN_RD: begin
                n_state = gtlw_pkg::ST_SCAN_CHK;
            end
            gtlw_pkg::ST_SCAN_CHK: begin
                n_first   = 1'b0;
                n_mode_sp = w_mode;
                if (w_found) begin
                    w_finish = 1'b1;
                end else begin
                    n_p     = r_p - gtlw_pkg::LEN_W'(1);
                    n_state = gtlw_pkg::ST_SCAN_RD;
                end
            end
            default: begin
                n_state = gtlw_pkg::ST_IDLE;
            end
        endcase

        if (w_finish) begin
            n_strobe = 1'b1;
            n_begin  = r_a;
            n_end    = w_line_end;
            n_num    = r_k;
            n_last   = w_k_last;
            if (w_k_last) begin
                n_len   = '0;
                n_ended = 1'b0;
                n_state = gtlw_pkg::ST_IDLE;
            end else begin
                n_a     = w_line_end;
                n_k     = r_k + gtlw_pkg::LINE_W'(1);
                n_state = r_skip ? gtlw_pkg::ST_TRIM_RD : gtlw_pkg::ST_LINE;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= gtlw_pkg::ST_IDLE;
            r_len       <= '0;
            r_ended     <= 1'b0;
            r_strobe    <= 1'b0;
            r_line_size <= gtlw_pkg::LINE_SIZE_RESET;
            r_skip      <= gtlw_pkg::SKIP_RESET;
        end else begin
            r_state  <= n_state;
            r_len    <= n_len;
            r_ended  <= n_ended;
            r_strobe <= n_strobe;
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    gtlw_pkg::CFG_LINE_SIZE:   r_line_size <= i_cfg_data;
                    gtlw_pkg::CFG_SKIP_SPACES: r_skip      <= i_cfg_data[0];
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_a       <= n_a;
        r_p       <= n_p;
        r_k       <= n_k;
        r_first   <= n_first;
        r_mode_sp <= n_mode_sp;
        r_begin   <= n_begin;
        r_end     <= n_end;
        r_num     <= n_num;
        r_last    <= n_last;
    end

    // text store, one write and one read port
    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_text_store[r_len[gtlw_pkg::ADDR_W-1:0]] <= i_text_byte;
        end
        if (r_state inside {gtlw_pkg::ST_TRIM_RD, gtlw_pkg::ST_SCAN_RD}) begin
            r_rdata <= r_text_store[w_rd_addr];
        end
    end

    assign o_busy        = r_state != gtlw_pkg::ST_IDLE;
    assign o_cfg_ready   = 1'b1;
    assign o_strobe      = r_strobe;
    assign o_line_begin  = r_begin;
    assign o_line_end    = r_end;
    assign o_line_number = r_num;
    assign o_last_line   = r_last;

    `GTLW_ASSERT_NOW(a_line_order, o_strobe, o_line_begin <= o_line_end)
    `GTLW_ASSERT_NOW(a_more_lines_busy, o_strobe && !o_last_line, o_busy)
    `GTLW_ASSERT_NOW(a_last_line_idle, o_strobe && o_last_line, !o_busy)
    `GTLW_ASSERT_NEXT(a_wrap_starts, i_start && !o_busy && i_end_of_text, o_busy)

endmodule

FILE: bench/tb_top.sv
`timescale 1ns / 100ps

module tb_top;

    localparam int CYCLE_LIMIT   = 600000;
    localparam int SETTLE_CYCLES = 8;
    localparam int DRAIN_CYCLES  = 64;
    localparam int PHASE_ITEMS   = 20;
    localparam int NUM_PHASES    = 10;

    typedef struct packed {
        logic [gtlw_pkg::LEN_W-1:0]  begin_ofs;
        logic [gtlw_pkg::LEN_W-1:0]  end_ofs;
        logic [gtlw_pkg::LINE_W-1:0] number;
        logic                        is_last;
    } t_line;

    typedef struct packed {
        logic [7:0] ch;
        logic       has;
        logic       eot;
    } t_text_item;

    typedef enum logic {ROW_ITEM, ROW_CFG} t_row_kind;

    typedef struct packed {
        t_row_kind                   kind;
        logic [gtlw_pkg::IDX_W-1:0]  cfg_idx;
        logic [gtlw_pkg::LS_W-1:0]   cfg_val;
        logic [7:0]                  ch;
        logic                        has;
        logic                        eot;
        logic                        typed;
        t_line                       want;
    } t_dir_row;

    localparam t_line NO_LINE = '0;

    logic                          i_clk = 1'b0;
    logic                          i_rst_n;
    logic                          i_start;
    logic                          o_busy;
    logic [7:0]                    i_text_byte;
    logic                          i_has_byte;
    logic                          i_end_of_text;
    logic                          o_strobe;
    logic [gtlw_pkg::LEN_W-1:0]    o_line_begin;
    logic [gtlw_pkg::LEN_W-1:0]    o_line_end;
    logic [gtlw_pkg::LINE_W-1:0]   o_line_number;
    logic                          o_last_line;
    logic                          i_cfg_valid;
    logic                          o_cfg_ready;
    logic [gtlw_pkg::IDX_W-1:0]    i_cfg_index;
    logic [gtlw_pkg::LS_W-1:0]     i_cfg_data;

    greedy_text_line_wrap_unit DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_start       (i_start),
        .o_busy        (o_busy),
        .i_text_byte   (i_text_byte),
        .i_has_byte    (i_has_byte),
        .i_end_of_text (i_end_of_text),
        .o_strobe      (o_strobe),
        .o_line_begin  (o_line_begin),
        .o_line_end    (o_line_end),
        .o_line_number (o_line_number),
        .o_last_line   (o_last_line),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // shadow of the block state
    logic [7:0]                model_mem [gtlw_pkg::MAX_CHARS];
    int                        model_len;
    bit                        model_ended;
    logic [gtlw_pkg::LS_W-1:0] model_ls;
    bit                        model_skip;

    t_line      pending_lines[$];
    t_text_item draft[$];
    int         mismatch_count;
    int         cycle_count;

    t_dir_row dir_rows [24] = '{
        '{ROW_ITEM, gtlw_pkg::CFG_LINE_SIZE, 9'd0, 8'h00, 1'b0, 1'b1, 1'b1,
          '{9'd0, 9'd0, 4'd0, 1'b1}},
        '{ROW_ITEM, gtlw_pkg::CFG_LINE_SIZE, 9'd0, 8'hFF, 1'b1, 1'b1, 1'b1,
          '{9'd0, 9'd1, 4'd0, 1'b1}},
        '{ROW_ITEM, gtlw_pkg::CFG_LINE_SIZE, 9'd0, gtlw_pkg::SPACE_CHAR, 1'b1, 1'b1, 1'b1,
          '{9'd1, 9'd1, 4'd0, 1'b1}},
        '{ROW_ITEM, gtlw_pkg::CFG_LINE_SIZE, 9'd0, 8'h61, 1'b1, 1'b0, 1'b0, NO_LINE},
        '{ROW_ITEM, gtlw_pkg::CFG_LINE_SIZE, 9'd0, 8'h00, 1'b1, 1'b0, 1'b0, NO_LINE},
        '{ROW_ITEM, gtlw_pkg::CFG_LINE_SIZE, 9'd0, 8'h62, 1'b1, 1'b1, 1'b1,
          '{9'd0, 9'd1, 4'd0, 1'b1}},
        '{ROW_ITEM, gtlw_pkg::CFG_LINE_SIZE, 9'd0, 8'h00, 1'b1, 1'b1, 1'b1,
          '{9'd0, 9'd0, 4'd0, 1'b1}},
        '{ROW_ITEM, gtlw_pkg::CFG_LINE_SIZE, 9'd0, 8'h55, 1'b0, 1'b0, 1'b0, NO_LINE},
        '{ROW_ITEM, gtlw_pkg::CFG_LINE_SIZE, 9'd0, 8'h63, 1'b1, 1'b1, 1'b1,
          '{9'd0, 9'd1, 4'd0, 1'b1}},
        '{ROW_CFG,  gtlw_pkg::CFG_LINE_SIZE, 9'd1, 8'h00, 1'b0, 1'b0, 1'b0, NO_LINE},
        '{ROW_ITEM, gtlw_pkg::CFG_LINE_SIZE, 9'd0, 8'h61, 1'b1, 1'b0, 1'b0, NO_LINE},
        '{ROW_ITEM, gtlw_pkg::CFG_LINE_SIZE, 9'd0, 8'h62, 1'b1, 1'b1, 1'b0, NO_LINE},
        '{ROW_CFG,  gtlw_pkg::CFG_LINE_SIZE, 9'd0, 8'h00, 1'b0, 1'b0, 1'b0, NO_LINE},
        '{ROW_ITEM, gtlw_pkg::CFG_LINE_SIZE, 9'd0, 8'h78, 1'b1, 1'b1, 1'b0, NO_LINE},
        '{ROW_CFG,  gtlw_pkg::CFG_LINE_SIZE, 9'd4, 8'h00, 1'b0, 1'b0, 1'b0, NO_LINE},
        '{ROW_ITEM, gtlw_pkg::CFG_LINE_SIZE, 9'd0, 8'h61, 1'b1, 1'b0, 1'b0, NO_LINE},
        '{ROW_ITEM, gtlw_pkg::CFG_LINE_SIZE, 9'd0, 8'h62, 1'b1, 1'b0, 1'b0, NO_LINE},
        '{ROW_ITEM, gtlw_pkg::CFG_LINE_SIZE, 9'd0, 8'h63, 1'b1, 1'b0, 1'b0, NO_LINE},
        '{ROW_ITEM, gtlw_pkg::CFG_LINE_SIZE, 9'd0, 8'h64, 1'b1, 1'b0, 1'b0, NO_LINE},
        '{ROW_ITEM, gtlw_pkg::CFG_LINE_SIZE, 9'd0, gtlw_pkg::SPACE_CHAR, 1'b1, 1'b0, 1'b0,
          NO_LINE},
        '{ROW_ITEM, gtlw_pkg::CFG_LINE_SIZE, 9'd0, gtlw_pkg::SPACE_CHAR, 1'b1, 1'b1, 1'b0,
          NO_LINE},
        '{ROW_CFG,  gtlw_pkg::CFG_SKIP_SPACES, 9'd0, 8'h00, 1'b0, 1'b0, 1'b0, NO_LINE},
        '{ROW_ITEM, gtlw_pkg::CFG_LINE_SIZE, 9'd0, gtlw_pkg::SPACE_CHAR, 1'b1, 1'b0, 1'b0,
          NO_LINE},
        '{ROW_ITEM, gtlw_pkg::CFG_LINE_SIZE, 9'd0, 8'h61, 1'b1, 1'b1, 1'b0, NO_LINE}
    };

    int phase_ls   [NUM_PHASES] = '{5, 1, 0, 256, 511, 12, 7, 3, 80, 2};
    bit phase_skip [NUM_PHASES] = '{1, 1, 0, 1, 0, 1, 0, 1, 1, 0};

    task automatic flag_mismatch(input string msg);
        $display("mismatch at %0t: %s", $realtime, msg);
        mismatch_count++;
    endtask

    function automatic logic [7:0] stored_char(input int idx);
        if (idx < 0 || idx >= gtlw_pkg::MAX_CHARS) return 8'h00;
        return model_mem[idx];
    endfunction

    function automatic void expect_line(input int b, input int e, input int k, input bit last);
        t_line ln;
        ln.begin_ofs = gtlw_pkg::LEN_W'(b);
        ln.end_ofs   = gtlw_pkg::LEN_W'(e);
        ln.number    = gtlw_pkg::LINE_W'(k);
        ln.is_last   = last;
        pending_lines.push_back(ln);
    endfunction

    // loads one byte and, at end of text, queues the lines of the wrap
    function automatic int load_byte_and_wrap(input t_text_item it);
        int len;
        int ls;
        int s;
        int size;
        int line_ofs;
        int cut;
        int n;
        bit finished;
        if (it.has && !model_ended) begin
            if (it.ch == 8'h00) begin
                model_ended = 1'b1;
            end else if (model_len < gtlw_pkg::MAX_CHARS) begin
                model_mem[model_len] = it.ch;
                model_len++;
            end
        end
        if (!it.eot) return 0;
        len = model_len;
        ls = (model_ls == '0) ? 1 : int'(model_ls);
        s = 0;
        line_ofs = 0;
        n = 0;
        finished = 1'b0;
        if (model_skip) begin
            while (s < len && stored_char(s) == gtlw_pkg::SPACE_CHAR) s++;
        end
        size = len - s;
        if (size < ls) begin
            expect_line(s, len, 0, 1'b1);
            n = 1;
        end else begin
            while (!finished && n < gtlw_pkg::MAX_LINES) begin
                cut = line_ofs + ls;
                if (cut >= size) begin
                    expect_line(s + line_ofs, s + size, n, 1'b1);
                    n++;
                    finished = 1'b1;
                end else begin
                    if (model_skip) begin
                        if (stored_char(s + cut) == gtlw_pkg::SPACE_CHAR) begin
                            while (cut >= 0 && stored_char(s + cut) == gtlw_pkg::SPACE_CHAR)
                                cut--;
                            if (cut >= 0) cut++;
                        end else begin
                            while (cut >= 0 && stored_char(s + cut) != gtlw_pkg::SPACE_CHAR)
                                cut--;
                        end
                    end
                    if (cut <= line_ofs) cut = line_ofs + ls;
                    expect_line(s + line_ofs, s + cut, n, n == gtlw_pkg::MAX_LINES - 1);
                    n++;
                    line_ofs = cut;
                    if (model_skip) begin
                        while (line_ofs < size &&
                               stored_char(s + line_ofs) == gtlw_pkg::SPACE_CHAR)
                            line_ofs++;
                    end
                end
            end
        end
        model_len = 0;
        model_ended = 1'b0;
        return n;
    endfunction

    // words of random content with runs of spaces, or plain noise
    function automatic void build_text(input int target, input bit noisy);
        t_text_item it;
        int word_max;
        int roll;
        draft.delete();
        word_max = $urandom_range(1, 12);
        if (noisy) begin
            repeat (target + 1) begin
                roll = $urandom_range(0, 9);
                it.has = (roll != 0);
                it.ch = (roll < 3) ? gtlw_pkg::SPACE_CHAR :
                        (roll == 3) ? 8'h00 : 8'($urandom_range(0, 255));
                it.eot = 1'b0;
                draft.push_back(it);
            end
        end else begin
            if ($urandom_range(0, 3) == 0) begin
                repeat ($urandom_range(1, 3))
                    draft.push_back('{gtlw_pkg::SPACE_CHAR, 1'b1, 1'b0});
            end
            while (draft.size() < target) begin
                repeat ($urandom_range(1, word_max))
                    draft.push_back('{8'($urandom_range(8'h21, 8'hFF)), 1'b1, 1'b0});
                repeat ($urandom_range(1, 3))
                    draft.push_back('{gtlw_pkg::SPACE_CHAR, 1'b1, 1'b0});
            end
            if ($urandom_range(0, 1) == 0) begin
                while (draft.size() > 0 && draft[$].ch == gtlw_pkg::SPACE_CHAR)
                    void'(draft.pop_back());
            end
            if ($urandom_range(0, 4) == 0)
                draft.push_back('{8'($urandom_range(0, 255)), 1'b0, 1'b0});
        end
        if (draft.size() == 0) draft.push_back('{8'h00, 1'b0, 1'b0});
        draft[$].eot = 1'b1;
    endfunction

    task automatic send_text_item(input t_text_item it, input int gap, output int lines);
        if (gap > 0) begin
            i_start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_start       <= 1'b1;
        i_text_byte   <= it.ch;
        i_has_byte    <= it.has;
        i_end_of_text <= it.eot;
        do @(posedge i_clk); while (o_busy);
        lines = load_byte_and_wrap(it);
    endtask

    task automatic write_reg(input logic [gtlw_pkg::IDX_W-1:0] idx,
                             input logic [gtlw_pkg::LS_W-1:0] val);
        i_start <= 1'b0;
        while (pending_lines.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        if (idx == gtlw_pkg::CFG_LINE_SIZE) model_ls = val;
        else model_skip = val[0];
    endtask

    always @(posedge i_clk) begin
        t_line want;
        if (i_rst_n && o_strobe) begin
            if (pending_lines.size() == 0) begin
                flag_mismatch($sformatf("line [%0d,%0d) number %0d with nothing expected",
                                        o_line_begin, o_line_end, o_line_number));
            end else begin
                want = pending_lines.pop_front();
                if (o_line_begin !== want.begin_ofs)
                    flag_mismatch($sformatf("line_begin %0d, expected %0d",
                                            o_line_begin, want.begin_ofs));
                if (o_line_end !== want.end_ofs)
                    flag_mismatch($sformatf("line_end %0d, expected %0d",
                                            o_line_end, want.end_ofs));
                if (o_line_number !== want.number)
                    flag_mismatch($sformatf("line_number %0d, expected %0d",
                                            o_line_number, want.number));
                if (o_last_line !== want.is_last)
                    flag_mismatch($sformatf("last_line %0b, expected %0b",
                                            o_last_line, want.is_last));
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    initial begin
        t_text_item it;
        int n;
        int target;
        int phase_items;
        bit no_gaps;
        bit noisy;
        mismatch_count = 0;
        cycle_count = 0;
        model_len = 0;
        model_ended = 1'b0;
        model_ls = gtlw_pkg::LINE_SIZE_RESET;
        model_skip = gtlw_pkg::SKIP_RESET;
        i_rst_n       <= 1'b0;
        i_start       <= 1'b0;
        i_text_byte   <= 8'h00;
        i_has_byte    <= 1'b0;
        i_end_of_text <= 1'b0;
        i_cfg_valid   <= 1'b0;
        i_cfg_index   <= gtlw_pkg::CFG_LINE_SIZE;
        i_cfg_data    <= '0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed rows
        foreach (dir_rows[r]) begin
            if (dir_rows[r].kind == ROW_CFG) begin
                write_reg(dir_rows[r].cfg_idx, dir_rows[r].cfg_val);
            end else begin
                it = '{dir_rows[r].ch, dir_rows[r].has, dir_rows[r].eot};
                send_text_item(it, $urandom_range(0, 7), n);
                if (dir_rows[r].typed) begin
                    repeat (n) void'(pending_lines.pop_back());
                    pending_lines.push_back(dir_rows[r].want);
                end
            end
        end

        // random texts over a sweep of settings
        for (int p = 0; p < NUM_PHASES; p++) begin
            write_reg(gtlw_pkg::CFG_LINE_SIZE, gtlw_pkg::LS_W'(phase_ls[p]));
            write_reg(gtlw_pkg::CFG_SKIP_SPACES, gtlw_pkg::LS_W'(phase_skip[p]));
            phase_items = 0;
            while (phase_items < PHASE_ITEMS) begin
                noisy = ($urandom_range(0, 4) == 0);
                target = $urandom_range(0, PHASE_ITEMS - phase_items);
                // many short lines run past the line limit
                if (phase_items == 0 && phase_ls[p] == 1) begin
                    noisy = 1'b0;
                    target = 30;
                end
                build_text(target, noisy);
                no_gaps = ($urandom_range(0, 3) == 0);
                foreach (draft[i]) begin
                    send_text_item(draft[i], no_gaps ? 0 : $urandom_range(0, 7), n);
                end
                phase_items += draft.size();
            end
        end

        i_start <= 1'b0;
        while (pending_lines.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
